@@ rtl/rdc_pkg.sv @@
`timescale 1ns / 1ps
package rdc_pkg;

    localparam int unsigned CordicStepsDefault = 30;
    localparam int unsigned AngW = 32;
    // CORDIC datapath width: Q2.30 plus guard bits for gain growth
    localparam int unsigned CW = 34;
    localparam logic signed [CW-1:0] GainStart = 34'sd652032874;
    localparam logic signed [35:0] QOne = 36'sd1073741824;

    localparam logic [0:0] CFG_RA0  = 1'b0;
    localparam logic [0:0] CFG_DEC0 = 1'b1;

    typedef struct packed {
        logic [31:0]        right_ascension;
        logic signed [31:0] declination;
    } t_in;

    typedef struct packed {
        logic signed [31:0] cos_l;
        logic signed [31:0] cos_m;
        logic signed [31:0] cos_n;
    } t_out;

    // per-stage CORDIC sample: two rotations in parallel plus folding flags
    typedef struct packed {
        logic signed [CW-1:0] xa;
        logic signed [CW-1:0] ya;
        logic signed [32:0]   za;
        logic                 fa;
        logic signed [CW-1:0] xd;
        logic signed [CW-1:0] yd;
        logic signed [32:0]   zd;
        logic                 fd;
    } t_rot;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001; 5'd31: r = 32'h00000000;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Q2.30 product with round half up, floor shift
    function automatic logic signed [35:0] qmul(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
        logic signed [71:0] p;
        begin
            p = (72'(a) * 72'(b)) + 72'sd536870912;
            return 36'(p >>> 30);
        end
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [35:0] v);
        logic signed [35:0] r;
        begin
            r = v;
            if (v > QOne) r = QOne;
            if (v < -QOne) r = -QOne;
            return r[31:0];
        end
    endfunction

endpackage

@@ rtl/rdc_cordic_stage.sv @@
`timescale 1ns / 1ps
// One registered CORDIC micro-rotation, applied to both angle lanes
module rdc_cordic_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rdc_pkg::t_rot     i_rot,
    output logic              o_valid,
    output rdc_pkg::t_rot     o_rot
);
    localparam logic signed [32:0] Atan = 33'({1'b0, rdc_pkg::atan_lut(5'(STEP))});

    rdc_pkg::t_rot n_rot;
    rdc_pkg::t_rot r_rot;
    logic          r_valid;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.za[32]) begin
            n_rot.xa = i_rot.xa - (i_rot.ya >>> STEP);
            n_rot.ya = i_rot.ya + (i_rot.xa >>> STEP);
            n_rot.za = i_rot.za - Atan;
        end else begin
            n_rot.xa = i_rot.xa + (i_rot.ya >>> STEP);
            n_rot.ya = i_rot.ya - (i_rot.xa >>> STEP);
            n_rot.za = i_rot.za + Atan;
        end
        if (!i_rot.zd[32]) begin
            n_rot.xd = i_rot.xd - (i_rot.yd >>> STEP);
            n_rot.yd = i_rot.yd + (i_rot.xd >>> STEP);
            n_rot.zd = i_rot.zd - Atan;
        end else begin
            n_rot.xd = i_rot.xd + (i_rot.yd >>> STEP);
            n_rot.yd = i_rot.yd - (i_rot.xd >>> STEP);
            n_rot.zd = i_rot.zd + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
endmodule

@@ rtl/rdc_centre_trig.sv @@
`timescale 1ns / 1ps
// Sine/cosine of the centre declination, recomputed serially after each
// declination write and after reset (centre declination zero)
module rdc_centre_trig #(
    parameter int unsigned CORDIC_STEPS = rdc_pkg::CordicStepsDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_ang,
    output logic signed [35:0]       o_sin,
    output logic signed [35:0]       o_cos
);
    localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

    logic                          r_busy;
    logic [CntW-1:0]               r_cnt;
    logic signed [rdc_pkg::CW-1:0] r_x, r_y;
    logic signed [32:0]            r_z;
    logic                          r_flip;
    logic [31:0]                   n_ang;
    logic [4:0]                    w_idx;
    logic signed [32:0]            w_at;
    logic signed [rdc_pkg::CW-1:0] w_dx, w_dy;

    assign n_ang = i_ang + 32'h4000_0000;
    assign w_idx = 5'(r_cnt);
    assign w_at  = 33'({1'b0, rdc_pkg::atan_lut(w_idx)});
    assign w_dx  = r_y >>> w_idx;
    assign w_dy  = r_x >>> w_idx;

    // reset loads angle zero and runs the rotations once it is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= rdc_pkg::GainStart;
            r_y    <= '0;
            r_z    <= '0;
            r_flip <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_x    <= rdc_pkg::GainStart;
            r_y    <= '0;
            r_flip <= n_ang[31];
            r_z    <= 33'($signed(n_ang[31] ? {~i_ang[31], i_ang[30:0]} : i_ang));
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CntW'(CORDIC_STEPS - 1)) r_busy <= 1'b0;
        end
    end

    assign o_sin = r_flip ? -36'(r_y) : 36'(r_y);
    assign o_cos = r_flip ? -36'(r_x) : 36'(r_x);
endmodule

@@ rtl/radec_to_direction_cosines.sv @@
`timescale 1ns / 1ps
// Direction cosines (l, m, n) of a source about a configured phase centre.
// Input channel: i_valid / o_stall carry {right_ascension, declination}.
// Output channel: o_valid / i_stall carry {cos_l, cos_m, cos_n}, Q2.30.
// Config: i_cfg_we with i_cfg_idx 0 = centre RA, 1 = centre declination.
// Write config only while idle; a declination write reruns a serial CORDIC,
// done before any item sent after the write reaches the centre products,
// so items may follow the write at once.
// Throughput: one transfer per cycle while the receiver does not stall.
// Pipeline: one fold stage, CORDIC_STEPS rotation stages, three multiply
// stages, one output register. Both angle lanes run through one shared
// CORDIC pipeline in parallel.
// Reset (synchronous, active low) empties the pipeline, clears the centre
// and reruns the serial CORDIC for a zero centre declination.
// Stall from the receiver freezes the whole pipeline; nothing is dropped;
// o_stall is then high only when the output holds a pending result.
module radec_to_direction_cosines #(
    parameter int unsigned CORDIC_STEPS = rdc_pkg::CordicStepsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  rdc_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output rdc_pkg::t_out o_data,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    logic [31:0]        r_ra0, r_dec0;
    logic signed [35:0] w_s0, w_c0;
    logic               w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra0  <= '0;
            r_dec0 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rdc_pkg::CFG_RA0:  r_ra0  <= i_cfg_data;
                rdc_pkg::CFG_DEC0: r_dec0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rdc_centre_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrig (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(!i_rst_n ? 1'b0 : (i_cfg_we && i_cfg_idx == rdc_pkg::CFG_DEC0)),
        .i_ang(i_cfg_data), .o_sin(w_s0), .o_cos(w_c0)
    );

    // whole pipeline advances unless output holds an untaken result
    logic r_ov;
    assign w_en    = !(r_ov && i_stall);
    assign o_stall = !w_en;

    // fold stage
    logic [31:0]   w_dra;
    rdc_pkg::t_rot n_fold;
    logic [31:0]   w_pa, w_pd;
    assign w_dra = i_data.right_ascension - r_ra0;
    assign w_pa  = w_dra + 32'h4000_0000;
    assign w_pd  = i_data.declination + 32'h4000_0000;
    always_comb begin
        n_fold.xa = rdc_pkg::GainStart;
        n_fold.ya = '0;
        n_fold.fa = w_pa[31];
        n_fold.za = 33'($signed(w_pa[31] ? {~w_dra[31], w_dra[30:0]} : w_dra));
        n_fold.xd = rdc_pkg::GainStart;
        n_fold.yd = '0;
        n_fold.fd = w_pd[31];
        n_fold.zd = 33'($signed(w_pd[31] ?
            {~i_data.declination[31], i_data.declination[30:0]} : i_data.declination));
    end

    rdc_pkg::t_rot s_rot [CORDIC_STEPS+1];
    logic          s_v   [CORDIC_STEPS+1];
    logic          r_fv;
    rdc_pkg::t_rot r_fold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (w_en) r_fv <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_fold <= n_fold;
    end
    assign s_rot[0] = r_fold;
    assign s_v[0]   = r_fv;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cord
        rdc_cordic_stage #(.STEP(g)) u_st (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(s_v[g]), .i_rot(s_rot[g]),
            .o_valid(s_v[g+1]), .o_rot(s_rot[g+1])
        );
    end

    // unfold results
    rdc_pkg::t_rot      w_r;
    logic signed [35:0] w_sa, w_ca, w_sd, w_cd;
    assign w_r  = s_rot[CORDIC_STEPS];
    assign w_sa = w_r.fa ? -36'(w_r.ya) : 36'(w_r.ya);
    assign w_ca = w_r.fa ? -36'(w_r.xa) : 36'(w_r.xa);
    assign w_sd = w_r.fd ? -36'(w_r.yd) : 36'(w_r.yd);
    assign w_cd = w_r.fd ? -36'(w_r.xd) : 36'(w_r.xd);

    // multiply stage 1: l product, t, and sin(dec) terms
    logic               r_v1, r_v2, r_v3;
    logic signed [35:0] r_l1, r_t1, r_sd1;
    logic signed [35:0] r_l2, r_a2, r_b2, r_c2, r_d2;
    logic signed [35:0] r_l3, r_m3, r_n3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= s_v[CORDIC_STEPS];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l1  <= rdc_pkg::qmul(w_sa, w_cd);
            r_t1  <= rdc_pkg::qmul(w_cd, w_ca);
            r_sd1 <= w_sd;
            // stage 2: four centre products
            r_l2 <= r_l1;
            r_a2 <= rdc_pkg::qmul(w_c0, r_sd1);
            r_b2 <= rdc_pkg::qmul(w_s0, r_t1);
            r_c2 <= rdc_pkg::qmul(w_s0, r_sd1);
            r_d2 <= rdc_pkg::qmul(w_c0, r_t1);
            // stage 3: combine
            r_l3 <= r_l2;
            r_m3 <= r_a2 - r_b2;
            r_n3 <= r_c2 + r_d2;
            // output register with saturation
            o_data.cos_l <= rdc_pkg::sat(r_l3);
            o_data.cos_m <= rdc_pkg::sat(r_m3);
            o_data.cos_n <= rdc_pkg::sat(r_n3);
        end
    end
    assign o_valid = r_ov;
endmodule

@@ tb/radec_to_direction_cosines_tb.sv @@
`timescale 1ns / 1ps
module radec_to_direction_cosines_tb;

    localparam int unsigned STEPS = 30;
    localparam int unsigned LATENCY = STEPS + 5;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_PER_PHASE = 230;
    localparam longint QONE = 64'sd1073741824;
    localparam longint GAIN = 64'sd652032874;

    localparam logic [31:0] ATAN_TBL [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    rdc_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    rdc_pkg::t_out o_data;
    logic          i_cfg_we;
    logic          i_cfg_idx;
    logic [31:0]   i_cfg_data;

    // phase centre as the predictor sees it
    logic [31:0] centre_ra;
    logic [31:0] centre_dec;

    rdc_pkg::t_out lmn_pending [$];
    int   n_errors;
    int   n_sent;
    int   idle_cycles;
    bit   stimulus_done;

    radec_to_direction_cosines #(.CORDIC_STEPS(STEPS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // rotation-mode CORDIC on a binary angle, folded to the right half plane
    task automatic cordic_sin_cos(input logic [31:0] ang, output longint sn,
                                  output longint cs);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [31:0] a;
        logic [31:0] probe;
        bit flip;
        x = GAIN;
        y = 0;
        a = ang;
        probe = a + 32'h40000000;
        flip = probe[31];
        if (flip) a = a ^ 32'h80000000;
        z = longint'($signed(a));
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TBL[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TBL[i]);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (QONE / 2)) >>> 30;
    endfunction

    function automatic logic [31:0] clamp_unit(input longint v);
        longint r;
        r = v;
        if (r > QONE) r = QONE;
        if (r < -QONE) r = -QONE;
        return r[31:0];
    endfunction

    task automatic lmn_predict(input rdc_pkg::t_in src, output rdc_pkg::t_out res);
        longint s_dra;
        longint c_dra;
        longint s_dec;
        longint c_dec;
        longint s_dec0;
        longint c_dec0;
        longint t;
        cordic_sin_cos(src.right_ascension - centre_ra, s_dra, c_dra);
        cordic_sin_cos(src.declination, s_dec, c_dec);
        cordic_sin_cos(centre_dec, s_dec0, c_dec0);
        t = q30_mul(c_dec, c_dra);
        res.cos_l = clamp_unit(q30_mul(s_dra, c_dec));
        res.cos_m = clamp_unit(q30_mul(c_dec0, s_dec) - q30_mul(s_dec0, t));
        res.cos_n = clamp_unit(q30_mul(s_dec0, s_dec) + q30_mul(c_dec0, t));
    endtask

    function automatic logic [31:0] rand_dec();
        // mostly legal declinations, now and then any bit pattern
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 32'h80000000) - 32'h40000000;
    endfunction

    // send one item after an optional random gap, hold it until the transfer happens
    task automatic send_item(input rdc_pkg::t_in item, input bit no_gaps);
        rdc_pkg::t_out res;
        int gap;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                             : $urandom_range(1, 3);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = item;
        do @(posedge i_clk); while (o_stall);
        lmn_predict(item, res);
        lmn_pending.push_back(res);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_centre(input logic [31:0] ra0, input logic [31:0] dec0);
        i_valid = 1'b0;
        // drain, then let the pipeline settle
        while (lmn_pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = rdc_pkg::CFG_RA0;
        i_cfg_data = ra0;
        @(negedge i_clk);
        i_cfg_idx = rdc_pkg::CFG_DEC0;
        i_cfg_data = dec0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        centre_ra = ra0;
        centre_dec = dec0;
        // centre declination rotation runs serially
        repeat (STEPS + 10) @(negedge i_clk);
    endtask

    // directed rows: field extremes, quadrant edges, declinations past a quarter turn
    localparam int N_DIRECTED = 18;
    localparam logic [63:0] DIRECTED [0:N_DIRECTED-1] = '{
        {32'h00000000, 32'h00000000}, {32'hFFFFFFFF, 32'h00000000},
        {32'h40000000, 32'h00000000}, {32'h80000000, 32'h00000000},
        {32'hC0000000, 32'h00000000}, {32'h7FFFFFFF, 32'h00000000},
        {32'h00000000, 32'h40000000}, {32'h00000000, 32'hC0000000},
        {32'h3FFFFFFF, 32'h3FFFFFFF}, {32'h40000001, 32'hC0000001},
        {32'h00000001, 32'h00000001}, {32'h00000000, 32'hFFFFFFFF},
        {32'h12345678, 32'h7FFFFFFF}, {32'h87654321, 32'h80000000},
        {32'hBFFFFFFF, 32'h40000001}, {32'h55555555, 32'hBFFFFFFF},
        {32'hAAAAAAAA, 32'h20000000}, {32'hFFFFFFFF, 32'hE0000000}
    };

    // sender
    initial begin
        rdc_pkg::t_in item;
        bit burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rdc_pkg::CFG_RA0;
        i_cfg_data = '0;
        centre_ra = '0;
        centre_dec = '0;
        n_sent = 0;
        stimulus_done = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (STEPS + 10) @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            item = DIRECTED[k];
            send_item(item, 1'b0);
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_centre(32'hFFFFFFFF, 32'h40000000);
                1: write_centre(32'h80000000, 32'hC0000000);
                2: write_centre($urandom, rand_dec());
                3: write_centre(32'h12345678, 32'h7FFFFFFF);
                default: write_centre(32'h00000000, 32'h00000000);
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
                item.right_ascension = $urandom;
                item.declination = rand_dec();
                send_item(item, burst);
            end
        end
        i_valid = 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        bit held;
        bit burst;
        int run;
        i_stall = 1'b1;
        held = 1'b0;
        burst = 1'b0;
        run = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                i_stall = 1'b1;
                repeat (200) @(negedge i_clk);
            end
            if (run == 0) begin
                burst = ($urandom_range(0, 3) == 0);
                run = $urandom_range(20, 80);
            end
            run--;
            if (burst || $urandom_range(0, 3) != 0) begin
                i_stall = 1'b0;
            end else begin
                i_stall = 1'b1;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(15, 50)) @(negedge i_clk);
            end
        end
    end

    // result checker and watchdog
    initial begin
        rdc_pkg::t_out exp_res;
        n_errors = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (i_rst_n && o_valid && !i_stall) begin
                if (lmn_pending.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_data);
                    n_errors++;
                end else begin
                    exp_res = lmn_pending.pop_front();
                    if (o_data.cos_l !== exp_res.cos_l) begin
                        $display("%0t: cos_l expected %0d actual %0d", $time,
                                 exp_res.cos_l, o_data.cos_l);
                        n_errors++;
                    end
                    if (o_data.cos_m !== exp_res.cos_m) begin
                        $display("%0t: cos_m expected %0d actual %0d", $time,
                                 exp_res.cos_m, o_data.cos_m);
                        n_errors++;
                    end
                    if (o_data.cos_n !== exp_res.cos_n) begin
                        $display("%0t: cos_n expected %0d actual %0d", $time,
                                 exp_res.cos_n, o_data.cos_n);
                        n_errors++;
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        bit timed_out;
        timed_out = 1'b0;
        @(posedge i_rst_n);
        while (!(stimulus_done && lmn_pending.size() == 0) && !timed_out) begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
        if (timed_out) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (n_errors == 0 && lmn_pending.size() == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
            $finish;
        end
    end

endmodule
